// ===== hw/rtl/behd_pkg.sv =====
// shared types and constants for the block entry header decoder
// no dependencies; every other file imports this package
`default_nettype none

package behd_pkg;

	// width of the buffer-remaining count that rides with each byte
	localparam int REMAIN_BITS = 24;

	// width that holds both the 33-bit length sum and the remaining count
	localparam int CMP_W = (REMAIN_BITS > 33) ? REMAIN_BITS : 33;

	localparam int LEN_W  = 32;
	localparam int HLEN_W = 4;

	localparam logic [7:0] PAYLOAD_MASK = 8'd127;
	localparam logic [4:0] LAST_SHIFT   = 5'd28;
	localparam logic [2:0] LAST_POS     = 3'd4;
	localparam logic [REMAIN_BITS-1:0] MIN_HEADER = REMAIN_BITS'(3);
	localparam logic [REMAIN_BITS-1:0] ONE_LEFT   = REMAIN_BITS'(1);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TRUNC = 2'd1,
		ST_LONG  = 2'd2,
		ST_BODY  = 2'd3
	} status_t;

	typedef struct packed {
		logic                   valid;
		logic [7:0]             data_byte;
		logic [REMAIN_BITS-1:0] bytes_left;
	} byte_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  shared_len;
		logic [LEN_W-1:0]  unshared_len;
		logic [LEN_W-1:0]  value_len;
		logic [HLEN_W-1:0] header_len;
		status_t           status;
	} result_t;

	// bit offset of a varint byte, the fifth byte and beyond land at 28
	function automatic logic [4:0] field_shift(input logic [2:0] pos);
		logic [4:0] sh;
		begin
			case (pos)
				3'd0:    sh = 5'd0;
				3'd1:    sh = 5'd7;
				3'd2:    sh = 5'd14;
				3'd3:    sh = 5'd21;
				default: sh = LAST_SHIFT;
			endcase
			return sh;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/behd_intf.sv =====
// valid/ready channel interfaces for header bytes and decoded results
// depends on behd_pkg
`default_nettype none

interface behd_byte_if
	import behd_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [7:0]             data_byte;
	logic [REMAIN_BITS-1:0] bytes_left;

	modport source (output valid, data_byte, bytes_left, input ready);
	modport sink   (input valid, data_byte, bytes_left, output ready);
endinterface

interface behd_result_if
	import behd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [LEN_W-1:0]  shared_len;
	logic [LEN_W-1:0]  unshared_len;
	logic [LEN_W-1:0]  value_len;
	logic [HLEN_W-1:0] header_len;
	status_t           status;

	modport source (output valid, shared_len, unshared_len, value_len, header_len, status,
		input ready);
	modport sink   (input valid, shared_len, unshared_len, value_len, header_len, status,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/behd_in_reg.sv =====
// input register stage: captures one header byte and its remaining count
// depends on behd_pkg
`default_nettype none

module behd_in_reg
	import behd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   take,
	input  wire logic                   advance,
	input  wire logic [7:0]             data_byte,
	input  wire logic [REMAIN_BITS-1:0] bytes_left,
	output      byte_item_t             item
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic [REMAIN_BITS-1:0] left_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= data_byte;
			left_s1 <= bytes_left;
		end
	end

	assign item = '{valid: valid_s1, data_byte: data_s1, bytes_left: left_s1};

endmodule

`default_nettype wire

// ===== hw/rtl/behd_core.sv =====
// varint field decoder: header state registers and the per-byte decision
// depends on behd_pkg
`default_nettype none

module behd_core
	import behd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire byte_item_t item,
	input  wire logic       advance,
	output      logic       emit,
	output      result_t    res
);

	logic [1:0]        field_q;
	logic [2:0]        pos_q;
	logic [LEN_W-1:0]  acc_q;
	logic [LEN_W-1:0]  first_q;
	logic [LEN_W-1:0]  second_q;
	logic [HLEN_W-1:0] cnt_q;

	logic                   more;
	logic [REMAIN_BITS-1:0] left;
	logic [HLEN_W-1:0]      hlen;
	logic [7:0]             part;
	logic [LEN_W-1:0]       acc_new;
	logic [CMP_W-1:0]       need;
	logic [CMP_W-1:0]       avail;
	logic                   fail;
	logic                   done;
	status_t                st;

	always_comb begin
		more    = item.data_byte[7];
		left    = item.bytes_left;
		hlen    = cnt_q + HLEN_W'(1);
		part    = more ? (item.data_byte & PAYLOAD_MASK) : item.data_byte;
		acc_new = acc_q | (LEN_W'(part) << field_shift(pos_q));
		need    = CMP_W'({1'b0, second_q}) + CMP_W'({1'b0, acc_new});
		avail   = CMP_W'(left - ONE_LEFT);
		fail    = 1'b1;
		done    = 1'b0;
		st      = ST_TRUNC;
		priority if (field_q == 2'd0 && pos_q == 3'd0 && left < MIN_HEADER) begin
			st = ST_TRUNC;
		end else if (left == '0) begin
			st = ST_TRUNC;
		end else if (more && pos_q >= LAST_POS) begin
			st = ST_LONG;
		end else if (more && left <= ONE_LEFT) begin
			st = ST_TRUNC;
		end else if (more) begin
			fail = 1'b0;
		end else if (field_q != 2'd2) begin
			// end of shared or unshared field, buffer must go on
			fail = (left <= ONE_LEFT);
		end else begin
			fail = 1'b0;
			done = 1'b1;
			st   = (avail < need) ? ST_BODY : ST_OK;
		end
	end

	assign emit = item.valid && (fail || done);

	always_comb begin
		res = '{shared_len: '0, unshared_len: '0, value_len: '0, header_len: hlen,
			status: st};
		if (done) begin
			res.shared_len   = first_q;
			res.unshared_len = second_q;
			res.value_len    = acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q  <= '0;
			pos_q    <= '0;
			acc_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			cnt_q    <= '0;
		end else if (advance) begin
			if (fail || done) begin
				field_q  <= '0;
				pos_q    <= '0;
				acc_q    <= '0;
				first_q  <= '0;
				second_q <= '0;
				cnt_q    <= '0;
			end else if (more) begin
				pos_q <= pos_q + 3'd1;
				acc_q <= acc_new;
				cnt_q <= hlen;
			end else begin
				if (field_q == 2'd0) begin
					first_q <= acc_new;
				end else begin
					second_q <= acc_new;
				end
				field_q <= field_q + 2'd1;
				pos_q   <= '0;
				acc_q   <= '0;
				cnt_q   <= hlen;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/block_entry_header_decoder_unit.sv =====
// top level of the block entry header decoder: input stage, decoder, result register
// depends on behd_pkg, behd_intf, behd_in_reg, behd_core
`default_nettype none

// Decodes the header of a sorted-table block entry, one byte per request on
// byte_ch, each byte tagged with the buffer bytes left counting itself. The
// three little-endian base-128 varints (shared, unshared and value length,
// each up to five bytes, bits above 31 dropped) come out as one request on
// result per header, with header_len and a status: ok, truncated buffer,
// overlong varint, or unshared key plus value larger than the rest of the buffer.
// Lengths read zero for truncated and overlong headers. After any result the
// decoder starts over at the next byte; body bytes must not be sent. One byte
// is taken every cycle: a byte passes the input register, the decode logic
// and lands in the result register, so the header state registers are updated
// as each byte is decoded and a result is offered from the result register. Input
// only waits when the result register is full and not being drained.

module block_entry_header_decoder_unit
	import behd_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	behd_byte_if.sink   byte_ch,
	behd_result_if.source result
);

	byte_item_t item;
	result_t    dec_res;
	result_t    res_q;
	logic       out_valid_q;
	logic       emit;
	logic       advance;
	logic       take;

	// the decode stage moves on when it holds a byte and the result register is empty or being drained
	assign advance       = item.valid && (!out_valid_q || result.ready);
	assign byte_ch.ready = !item.valid || advance;
	assign take          = byte_ch.valid && byte_ch.ready;

	behd_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.advance    (advance),
		.data_byte  (byte_ch.data_byte),
		.bytes_left (byte_ch.bytes_left),
		.item       (item)
	);

	behd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.advance (advance),
		.emit    (emit),
		.res     (dec_res)
	);

	// result register, refilled in the same cycle it is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= dec_res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.shared_len   = res_q.shared_len;
	assign result.unshared_len = res_q.unshared_len;
	assign result.value_len    = res_q.value_len;
	assign result.header_len   = res_q.header_len;
	assign result.status       = res_q.status;

endmodule

`default_nettype wire
